>>> src/false_color_palette_map_unit_defines.svh
// Assertion macros shared by the false-colour palette map checker.
`ifndef FALSE_COLOR_PALETTE_MAP_UNIT_DEFINES_SVH
`define FALSE_COLOR_PALETTE_MAP_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define FCPM_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define FCPM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fcpm_pkg.sv
// Shared widths, constants, types and functions of the false-colour palette map.
package fcpm_pkg;

  localparam int SampleW  = 32;
  localparam int ColorW   = 8;
  localparam int AddrW    = 3;
  localparam int DiffW    = SampleW + 1;
  localparam int DivW     = SampleW;
  localparam int QuoW     = 11;
  localparam int RemW     = DivW + QuoW;
  localparam int NumW     = RemW + 2;
  localparam int ChanW    = 13;

  // 1020 * x is formed as x * 1024 - x * 4
  localparam int ScaleHi  = 10;
  localparam int ScaleLo  = 2;
  // Quotient is biased by 256 so that it stays unsigned
  localparam int OffsetShift = 8;
  localparam int VOffset     = 2 ** OffsetShift;

  localparam logic signed [SampleW-1:0] RangeMinReset = SampleW'(0);
  localparam logic signed [SampleW-1:0] RangeMaxReset = SampleW'(65536);

  // Breakpoints of the four tent functions on the 0..1020 scale
  localparam logic signed [ChanW-1:0] RedRise    = ChanW'(389);
  localparam logic signed [ChanW-1:0] RedFall    = ChanW'(1155);
  localparam logic signed [ChanW-1:0] GreenRiseA = ChanW'(133);
  localparam logic signed [ChanW-1:0] GreenFallA = ChanW'(644);
  localparam logic signed [ChanW-1:0] GreenRiseB = ChanW'(392);
  localparam logic signed [ChanW-1:0] GreenFallB = ChanW'(900);
  localparam logic signed [ChanW-1:0] BlueRise   = ChanW'(-127);
  localparam logic signed [ChanW-1:0] BlueFall   = ChanW'(640);

  localparam logic [ColorW-1:0] ColorFull = {ColorW{1'b1}};

  typedef enum logic {
    REG_RANGE_MIN = 1'b0,
    REG_RANGE_MAX = 1'b1
  } fcpm_reg_t;

  typedef struct packed {
    logic empty;  // range_max <= range_min
    logic hot;    // sample above range_max
  } fcpm_flags_t;

  typedef struct packed {
    fcpm_flags_t            flags;
    logic [RemW-1:0]        rem;
    logic [RemW-1:0]        div;
    logic [QuoW-1:0]        quo;
  } fcpm_div_t;

  // Floor of min(v - rise, fall - v), given floor and ceiling of v
  function automatic logic signed [ChanW-1:0] tent(
    input logic signed [ChanW-1:0] fl,
    input logic signed [ChanW-1:0] ce,
    input logic signed [ChanW-1:0] rise,
    input logic signed [ChanW-1:0] fall
  );
    logic signed [ChanW-1:0] up;
    logic signed [ChanW-1:0] down;
    up   = fl - rise;
    down = fall - ce;
    return (up < down) ? up : down;
  endfunction

  // Clamp a channel value to 0..255
  function automatic logic [ColorW-1:0] clamp_chan(input logic signed [ChanW-1:0] a);
    logic [ColorW-1:0] res;
    if (a < 0) begin
      res = '0;
    end else if (a > $signed(ChanW'(ColorFull))) begin
      res = ColorFull;
    end else begin
      res = a[ColorW-1:0];
    end
    return res;
  endfunction

endpackage

>>> src/fcpm_sample_if.sv
// Sample channel: valid/ready handshake carrying one signed Q16.16 sample.
interface fcpm_sample_if import fcpm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> src/fcpm_color_if.sv
// Colour channel: valid/ready handshake carrying one 8-bit RGB triple.
interface fcpm_color_if import fcpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] red;
  logic [ColorW-1:0] green;
  logic [ColorW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> src/fcpm_front.sv
// Front stages: offset from range_min, scale by 1020, bias and clamp the dividend.
module fcpm_front import fcpm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [SampleW-1:0] range_min,
  input  logic signed [SampleW-1:0] range_max,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SampleW-1:0] sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fcpm_div_t                 out_data
);

  logic                    a_valid;
  logic signed [DiffW-1:0] a_diff;
  logic signed [DiffW-1:0] a_span;
  fcpm_flags_t             a_flags;
  logic                    a_load;

  logic                    b_valid;
  logic signed [NumW-1:0]  b_num;
  logic [DivW-1:0]         b_div;
  fcpm_flags_t             b_flags;
  logic                    b_load;
  logic signed [NumW-1:0]  b_num_next;

  logic                    c_load;
  logic [RemW:0]           c_limit;
  logic [RemW-1:0]         c_rem_next;

  // Each stage loads when empty or when its successor loads
  assign c_load   = !out_valid || out_ready;
  assign b_load   = !b_valid || c_load;
  assign a_load   = !a_valid || b_load;
  assign in_ready = a_load;

  // Scale the offset by 1020 and add 256 spans, so the quotient is v + 256
  assign b_num_next = (NumW'(a_diff) <<< ScaleHi) - (NumW'(a_diff) <<< ScaleLo)
                    + (NumW'(a_span) <<< OffsetShift);

  // Limit the dividend to [0, span * 2^QuoW) so the quotient fits
  assign c_limit = {1'b0, b_div, {QuoW{1'b0}}};

  always_comb begin
    priority if (b_num < 0) begin
      c_rem_next = '0;
    end else if (b_num >= $signed(NumW'(c_limit))) begin
      c_rem_next = RemW'(c_limit - (RemW + 1)'(1));
    end else begin
      c_rem_next = b_num[RemW-1:0];
    end
  end

  // Advance the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid <= in_valid;
      end
      if (b_load) begin
        b_valid <= a_valid;
      end
      if (c_load) begin
        out_valid <= b_valid;
      end
    end
    if (a_load) begin
      a_diff        <= DiffW'(sample) - DiffW'(range_min);
      a_span        <= DiffW'(range_max) - DiffW'(range_min);
      a_flags.empty <= (range_max <= range_min);
      a_flags.hot   <= (sample > range_max);
    end
    if (b_load) begin
      b_num   <= b_num_next;
      b_div   <= a_span[DivW-1:0];
      b_flags <= a_flags;
    end
    if (c_load) begin
      out_data.flags <= b_flags;
      out_data.rem   <= c_rem_next;
      out_data.div   <= RemW'({b_div, {(QuoW - 1){1'b0}}});
      out_data.quo   <= '0;
    end
  end

endmodule

>>> src/fcpm_div_cell.sv
// Divider cell: settle one quotient bit and hand the partial remainder on.
module fcpm_div_cell import fcpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  fcpm_div_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output fcpm_div_t out_data
);

  logic      take;
  fcpm_div_t data_next;

  assign in_ready = !out_valid || out_ready;

  // Subtract the shifted divisor where it fits, then halve the divisor
  always_comb begin
    take            = (in_data.rem >= in_data.div);
    data_next.flags = in_data.flags;
    data_next.rem   = take ? (in_data.rem - in_data.div) : in_data.rem;
    data_next.div   = in_data.div >> 1;
    data_next.quo   = {in_data.quo[QuoW-2:0], take};
  end

  // Hold while the next cell is full and stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

>>> src/fcpm_color_cell.sv
// Colour cell: turn quotient and remainder flag into the RGB triple, output register.
module fcpm_color_cell import fcpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fcpm_div_t         in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ColorW-1:0] red,
  output logic [ColorW-1:0] green,
  output logic [ColorW-1:0] blue
);

  logic signed [ChanW-1:0] fl;
  logic signed [ChanW-1:0] ce;
  logic signed [ChanW-1:0] green_a;
  logic signed [ChanW-1:0] green_b;
  logic [ColorW-1:0]       red_next;
  logic [ColorW-1:0]       green_next;
  logic [ColorW-1:0]       blue_next;

  assign in_ready = !out_valid || out_ready;

  // Remove the bias of 256; a non-zero remainder lifts the ceiling by one
  always_comb begin
    fl      = $signed(ChanW'(in_data.quo)) - $signed(ChanW'(VOffset));
    ce      = fl + $signed(ChanW'(|in_data.rem));
    green_a = tent(fl, ce, GreenRiseA, GreenFallA);
    green_b = tent(fl, ce, GreenRiseB, GreenFallB);
    if (in_data.flags.empty) begin
      red_next   = in_data.flags.hot ? ColorFull : '0;
      green_next = red_next;
      blue_next  = red_next;
    end else begin
      red_next   = clamp_chan(tent(fl, ce, RedRise, RedFall));
      green_next = clamp_chan((green_a > green_b) ? green_a : green_b);
      blue_next  = clamp_chan(tent(fl, ce, BlueRise, BlueFall));
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

>>> src/false_color_palette_map_unit.sv
// Top level of the false-colour palette map: register port and the cell chain.
//
// Maps each signed Q16.16 sample on the sample channel to an 8-bit RGB
// jet-colour triple on the colour channel, using the range set by
// range_min (byte address 0) and range_max (byte address 4) on the APB
// port. Change the range only while no sample is in flight.
// The sample passes three front stages, eleven divider cells (one quotient
// bit each) and the output register, fifteen registers in all. Throughput:
// one sample per cycle while the receiver is ready; every cell passes its
// contents on each cycle unless stalled, so the divider chain sets the
// latency.
// When the receiver stalls, the output register holds its triple; ready is
// passed back through the cells without a register, so empty cells keep
// loading and samples are still taken until all fifteen stages are full,
// after which the sample channel is refused in the same cycle.
// Reset: synchronous; empties every cell and returns the range to 0..1.0.
module false_color_palette_map_unit import fcpm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  fcpm_sample_if.sink        sample_ch,
  fcpm_color_if.source       color_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [SampleW-1:0] pwdata,
  output logic [SampleW-1:0] prdata,
  output logic               pready
);

  logic signed [SampleW-1:0] range_min;
  logic signed [SampleW-1:0] range_max;
  fcpm_reg_t                 reg_sel;

  logic [QuoW:0]             chain_valid;
  logic [QuoW:0]             chain_ready;
  fcpm_div_t                 chain_data [QuoW+1];

  assign reg_sel = fcpm_reg_t'(paddr[2]);
  assign pready  = 1'b1;

  // Write the range registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= RangeMinReset;
      range_max <= RangeMaxReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_RANGE_MIN: range_min <= pwdata;
        REG_RANGE_MAX: range_max <= pwdata;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (reg_sel)
      REG_RANGE_MIN: prdata = range_min;
      REG_RANGE_MAX: prdata = range_max;
    endcase
  end

  fcpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .range_min (range_min),
    .range_max (range_max),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .sample    (sample_ch.sample),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  // One divider cell per quotient bit, most significant first
  for (genvar k = 0; k < QuoW; k++) begin : g_cell
    fcpm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  fcpm_color_cell u_color (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[QuoW]),
    .in_ready  (chain_ready[QuoW]),
    .in_data   (chain_data[QuoW]),
    .out_valid (color_ch.valid),
    .out_ready (color_ch.ready),
    .red       (color_ch.red),
    .green     (color_ch.green),
    .blue      (color_ch.blue)
  );

endmodule

>>> src/fcpm_checker.sv
// Port-level checks of the false-colour palette map and their bind.
`include "false_color_palette_map_unit_defines.svh"

module fcpm_checker import fcpm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ColorW-1:0]  red,
  input logic [ColorW-1:0]  green,
  input logic [ColorW-1:0]  blue,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [AddrW-1:0]   paddr,
  input logic [SampleW-1:0] pwdata,
  input logic [SampleW-1:0] prdata,
  input logic               pready
);

  // A stalled colour holds its value
  `FCPM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable({red, green, blue}), "stalled colour changed")

  // With the output register empty the whole chain can take a sample
  `FCPM_ASSERT_NOW(a_ready_when_drained, clk, rst, !out_valid, in_ready, "sample refused with empty output")

  // Reset empties the chain
  `FCPM_ASSERT_NEXT(a_reset_drains, clk, 1'b0, rst, !out_valid && !in_valid || !out_valid, "colour valid after reset")

  // A register reads back what was written to it
  `FCPM_ASSERT_NOW(a_readback, clk, rst, (!rst && psel && penable && pwrite && pready) ##1 (paddr[2] == $past(paddr[2])), prdata == $past(pwdata), "register read-back mismatch")

endmodule

bind false_color_palette_map_unit fcpm_checker u_fcpm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_ch.valid),
  .in_ready  (sample_ch.ready),
  .out_valid (color_ch.valid),
  .out_ready (color_ch.ready),
  .red       (color_ch.red),
  .green     (color_ch.green),
  .blue      (color_ch.blue),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

>>> test/false_color_palette_map_unit_tb.sv
// Testbench for the false-colour palette map: APB range set-up, sample stream, colour scoreboard.
`timescale 1ns / 100ps

module false_color_palette_map_unit_tb;
  import fcpm_pkg::*;

  localparam longint SampleMaxL = 64'sh7FFF_FFFF;
  localparam longint SampleMinL = -64'sh8000_0000;
  localparam int     HoldAfter  = 500;  // results before the long receiver hold-off
  localparam int     HoldCycles = 300;
  localparam int     SettleCycles = 20; // settle time after the last colour

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } rgb_t;

  // Predicts the jet colour of each accepted sample and checks the colours in order
  class palette_scoreboard;
    rgb_t   colour_q[$];
    longint range_lo;
    longint range_hi;
    int     mismatches;

    function new();
      range_lo   = 0;
      range_hi   = 65536;
      mismatches = 0;
    endfunction

    function void set_range(fcpm_reg_t idx, logic [SampleW-1:0] val);
      if (idx == REG_RANGE_MIN) begin
        range_lo = longint'($signed(val));
      end else begin
        range_hi = longint'($signed(val));
      end
    endfunction

    function void flag_mismatch(string what, longint exp_v, longint act_v);
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, act_v);
      end
    endfunction

    // floor(min(v - rise, fall - v)) from floor and ceiling of v
    function longint tent_floor(longint fl, longint ce, longint rise, longint fall);
      longint up;
      longint down;
      up   = fl - rise;
      down = fall - ce;
      return (up < down) ? up : down;
    endfunction

    function logic [ColorW-1:0] saturate_level(longint a);
      if (a < 0) return '0;
      if (a > 255) return ColorFull;
      return a[ColorW-1:0];
    endfunction

    function rgb_t predict_colour(logic signed [SampleW-1:0] sample);
      longint s;
      longint d;
      longint num;
      longint q;
      longint r;
      longint fl;
      longint ce;
      longint ga;
      longint gb;
      rgb_t   c;
      s = longint'(sample);
      d = range_hi - range_lo;
      // empty or inverted range: all on above the top, else all off
      if (d <= 0) begin
        c.red   = (s > range_hi) ? ColorFull : '0;
        c.green = c.red;
        c.blue  = c.red;
        return c;
      end
      // exact v = 1020 * (s - lo) / d, floor and ceiling from one division
      num = 1020 * (s - range_lo);
      q   = num / d;
      r   = num % d;
      fl  = (r < 0) ? q - 1 : q;
      ce  = (r > 0) ? q + 1 : q;
      c.red   = saturate_level(tent_floor(fl, ce, 389, 1155));
      ga      = tent_floor(fl, ce, 133, 644);
      gb      = tent_floor(fl, ce, 392, 900);
      c.green = saturate_level((ga > gb) ? ga : gb);
      c.blue  = saturate_level(tent_floor(fl, ce, -127, 640));
      return c;
    endfunction

    function void note_sample(logic signed [SampleW-1:0] sample);
      colour_q.push_back(predict_colour(sample));
    endfunction

    function void check_colour(rgb_t got);
      rgb_t want;
      if (colour_q.size() == 0) begin
        flag_mismatch("colour with no sample outstanding", 0, got);
        return;
      end
      want = colour_q.pop_front();
      if (got.red !== want.red) flag_mismatch("red", want.red, got.red);
      if (got.green !== want.green) flag_mismatch("green", want.green, got.green);
      if (got.blue !== want.blue) flag_mismatch("blue", want.blue, got.blue);
    endfunction

    function int pending();
      return colour_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [SampleW-1:0] pwdata;
  logic [SampleW-1:0] prdata;
  logic               pready;
  bit                 stall_on;

  palette_scoreboard board = new();

  fcpm_sample_if sample_ch ();
  fcpm_color_if  color_ch ();

  false_color_palette_map_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .sample_ch(sample_ch),
    .color_ch (color_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_gap();
    if (!stall_on) return 0;
    return $urandom_range(0, 9);
  endfunction

  // Mostly samples around the range, some near its ends, some anywhere
  function automatic logic [SampleW-1:0] pick_sample(longint lo, longint hi);
    longint      d;
    longint      v;
    logic [63:0] rnd;
    logic [63:0] modulus;
    int          kind;
    kind = $urandom_range(0, 9);
    rnd  = {$urandom, $urandom};
    d    = hi - lo;
    if (kind < 2) begin
      v = longint'($signed($urandom));
    end else if (d <= 0) begin
      v = hi + longint'($urandom_range(0, 8)) - 4;
    end else if (kind < 4) begin
      v = ((kind == 2) ? lo : hi) + longint'($urandom_range(0, 16)) - 8;
    end else begin
      modulus = d + d / 2 + 1;
      v = lo - d / 4 + longint'(rnd % modulus);
    end
    if (v > SampleMaxL) v = SampleMaxL;
    if (v < SampleMinL) v = SampleMinL;
    return v[SampleW-1:0];
  endfunction

  // Write one range register, then read it back
  task automatic write_reg(input fcpm_reg_t idx, input logic [SampleW-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = AddrW'(int'(idx) * 4);
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_range(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    psel    = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) board.flag_mismatch("register read-back", val, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_range(input logic [SampleW-1:0] lo, input logic [SampleW-1:0] hi);
    write_reg(REG_RANGE_MIN, lo);
    write_reg(REG_RANGE_MAX, hi);
  endtask

  // Offer one sample after a random gap and hold it until the transfer
  task automatic send_sample(input logic [SampleW-1:0] s);
    int gap;
    gap = draw_gap();
    repeat (gap) @(negedge clk) sample_ch.valid = 1'b0;
    @(negedge clk);
    sample_ch.valid  = 1'b1;
    sample_ch.sample = s;
    do @(posedge clk); while (!sample_ch.ready);
    board.note_sample(s);
  endtask

  task automatic send_list(input logic [SampleW-1:0] list[$]);
    foreach (list[i]) send_sample(list[i]);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_sample(pick_sample(board.range_lo, board.range_hi));
  endtask

  // Drop valid, wait for every colour, then let the pipeline settle
  task automatic drain_colours();
    @(negedge clk) sample_ch.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Colour receiver: random stalls, one long hold-off part way through
  initial begin
    int   gap;
    int   seen;
    bit   held;
    rgb_t got;
    seen = 0;
    held = 1'b0;
    color_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (!held && seen >= HoldAfter) begin
        held = 1'b1;
        repeat (HoldCycles) @(negedge clk) color_ch.ready = 1'b0;
      end
      gap = draw_gap();
      repeat (gap) @(negedge clk) color_ch.ready = 1'b0;
      @(negedge clk) color_ch.ready = 1'b1;
      do @(posedge clk); while (!color_ch.valid);
      got.red   = color_ch.red;
      got.green = color_ch.green;
      got.blue  = color_ch.blue;
      board.check_colour(got);
      seen++;
    end
  end

  // Stimulus: one phase per range setting
  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    stall_on         = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // reset range 0..1.0, ends of the sample field
    send_list('{32'h0000_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF});
    send_random(150);
    drain_colours();

    // unit scale: v equals the sample, so breakpoints land exactly
    set_range(32'd0, 32'd1020);
    stall_on = 1'b0;
    send_list('{-32'sd127, 32'd133, 32'd389, 32'd392, 32'd640, 32'd644, 32'd900,
                32'd1155, 32'd1156});
    send_random(150);
    drain_colours();
    stall_on = 1'b1;

    // odd divisor: one sample below the range and one inside it
    set_range(32'd0, 32'd3);
    send_list('{32'hFFFF_FFFF, 32'd1});
    send_random(60);
    drain_colours();

    // widest range
    set_range(32'h8000_0000, 32'h7FFF_FFFF);
    send_list('{32'h8000_0000, 32'h7FFF_FFFF});
    send_random(150);
    drain_colours();

    // empty range
    set_range(32'h0012_3456, 32'h0012_3456);
    send_list('{32'h0012_3456, 32'h0012_3457});
    send_random(100);
    drain_colours();

    // inverted range at the extremes
    set_range(32'h7FFF_FFFF, 32'h8000_0000);
    send_list('{32'h8000_0000});
    send_random(100);
    drain_colours();

    // narrowest non-empty range
    set_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_random(80);
    drain_colours();

    // random ranges, one of them without idling
    for (int p = 0; p < 4; p++) begin
      set_range($urandom, $urandom);
      stall_on = (p != 2);
      send_random(110);
      drain_colours();
    end
    stall_on = 1'b1;

    if (board.mismatches == 0) begin
      $display("false_color_palette_map_unit test passed");
    end else begin
      $display("false_color_palette_map_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #800000;
    $display("false_color_palette_map_unit test failed");
    $finish;
  end

endmodule
